FILE: sv/imuctf_pkg.sv
// ----------------------------------------------------------------------------
// imuctf_pkg
// Shared types, widths and constants for the complementary tilt filter.
// ----------------------------------------------------------------------------
package imuctf_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int unsigned SAMPLE_W = 16;   // raw sensor word
  localparam int unsigned TILT_W   = 17;   // output angle, 2^-8 degree
  localparam int unsigned ANGLE_W  = 26;   // stored angle, 2^-16 degree
  localparam int unsigned ADDR_W   = 3;    // byte address of the register file
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned ROOT_W   = 24;   // floor(sqrt(48-bit radicand))
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned REM_W    = ROOT_W + 3;
  localparam int unsigned CORD_W   = 28;   // CORDIC x and y
  localparam int unsigned ZANG_W   = 25;   // CORDIC angle accumulator
  localparam int unsigned ATAN_W   = 23;   // one arctangent table entry
  localparam int unsigned STEP_W   = 5;    // step counter for root and CORDIC

  localparam int unsigned MUL_A_W  = 18;
  localparam int unsigned MUL_B_W  = 35;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W    = 51;   // blend accumulator, 2^-32 degree

  localparam logic [15:0] BLEND_GAIN_RST = 16'd55706;
  localparam logic [31:0] STEP_GAIN_RST  = 32'd327862;

  localparam logic signed [35:0] ANG_MAX = 36'sd16777215;
  localparam logic signed [35:0] ANG_MIN = -36'sd16777216;

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_BLEND_GAIN = 1'b0;
  localparam logic REG_STEP_GAIN  = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQA   = 9'b000000010,
    S_SQB   = 9'b000000100,
    S_SQSUM = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_CORD  = 9'b000100000,
    S_BLG   = 9'b001000000,
    S_BLT   = 9'b010000000,
    S_SAT   = 9'b100000000
  } state_t;

  // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary accelerometer/gyro tilt filter with a shared CORDIC datapath.
// ----------------------------------------------------------------------------
// Each sample runs the 24-step square root and then the CORDIC loop once
// per axis on the same datapath, x tilt first. in_stall is high outside
// S_IDLE, so a new sample is taken only after both axes are done.
// Reset (rst_n low, synchronous) clears both angles to zero, loads the
// default gains and empties the output register.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter #(
  parameter int unsigned CORDIC_STEPS = imuctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [imuctf_pkg::SAMPLE_W-1:0]    in_accel_x,
  input  logic signed [imuctf_pkg::SAMPLE_W-1:0]    in_accel_y,
  input  logic signed [imuctf_pkg::SAMPLE_W-1:0]    in_accel_z,
  input  logic signed [imuctf_pkg::SAMPLE_W-1:0]    in_gyro_x,
  input  logic signed [imuctf_pkg::SAMPLE_W-1:0]    in_gyro_y,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [imuctf_pkg::TILT_W-1:0]      out_tilt_x,
  output logic signed [imuctf_pkg::TILT_W-1:0]      out_tilt_y,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic        [imuctf_pkg::ADDR_W-1:0]      paddr,
  input  logic        [imuctf_pkg::DATA_W-1:0]      pwdata,
  output logic        [imuctf_pkg::DATA_W-1:0]      prdata,
  output logic                                      pready
);
  import imuctf_pkg::*;

  // The step counter is shared by the root and the CORDIC loop.
  localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  // Sequencer state. Axis 0 is the x tilt, axis 1 the y tilt.
  state_t                     state_r;
  logic                       axis_r;
  logic [STEP_W-1:0]          cnt_r;

  // Captured sample.
  logic signed [SAMPLE_W-1:0] ax_r, ay_r, az_r, gx_r, gy_r;

  // Configuration and filter state.
  logic [15:0]                blend_gain_r;
  logic [31:0]                step_gain_r;
  logic signed [ANGLE_W-1:0]  angle_x_r, angle_y_r;

  // Datapath registers.
  logic signed [MUL_P_W-1:0]  prod_r;
  logic [31:0]                sq_r;
  logic [RAD_W-1:0]           rad_r;
  logic [REM_W-1:0]           rem_r;
  logic [ROOT_W-1:0]          root_r;
  logic signed [CORD_W-1:0]   cx_r, cy_r;
  logic signed [ZANG_W-1:0]   cz_r;
  logic signed [ZANG_W-1:0]   tilt_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_valid_r;
  logic signed [TILT_W-1:0]   out_x_r, out_y_r;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are
  // returned the same cycle. Bit 2 of the byte address picks the register.
  // --------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_STEP_GAIN) ? step_gain_r : {16'd0, blend_gain_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_gain_r <= BLEND_GAIN_RST;
      step_gain_r  <= STEP_GAIN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_STEP_GAIN) begin
        step_gain_r <= pwdata;
      end else begin
        blend_gain_r <= pwdata[15:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis operand selection. The x tilt is atan2(ay, |ax,az|); the y tilt
  // is -atan2(ax, |ay,az|).
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] num, opa, gyro;
  logic signed [ANGLE_W-1:0]  angle;

  assign num   = axis_r ? ax_r : ay_r;
  assign opa   = axis_r ? ay_r : ax_r;
  assign gyro  = axis_r ? gy_r : gx_r;
  assign angle = axis_r ? angle_y_r : angle_x_r;

  // --------------------------------------------------------------------------
  // Gyro increment and unfiltered sum. prod_r holds gyro * step gain from the
  // S_SQSUM cycle until S_BLG, where it is rounded half up to 2^-16 degree.
  // --------------------------------------------------------------------------
  logic signed [48:0] gprod_rnd;
  logic signed [32:0] delta;
  logic signed [33:0] sum;

  assign gprod_rnd = 49'($signed(prod_r[47:0])) + 49'sd32768;
  assign delta     = gprod_rnd[48:16];
  assign sum       = 34'(angle) + 34'(delta);

  // --------------------------------------------------------------------------
  // Shared multiplier. Its operands are steered by the state, and the product
  // is always registered before use.
  // --------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  logic signed [MUL_P_W-1:0] mul_p;
  logic        [16:0]        one_minus_g;

  assign one_minus_g = 17'h10000 - {1'b0, blend_gain_r};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_SQA: begin
        ma = MUL_A_W'(opa);
        mb = MUL_B_W'(opa);
      end
      S_SQB: begin
        ma = MUL_A_W'(az_r);
        mb = MUL_B_W'(az_r);
      end
      S_SQSUM: begin
        ma = MUL_A_W'(gyro);
        mb = $signed({3'b000, step_gain_r});
      end
      S_BLG: begin
        ma = $signed({2'b00, blend_gain_r});
        mb = MUL_B_W'(sum);
      end
      S_BLT: begin
        ma = $signed({1'b0, one_minus_g});
        mb = MUL_B_W'(tilt_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(ma) * MUL_P_W'(mb);

  // --------------------------------------------------------------------------
  // Digit-by-digit square root, one result bit per cycle.
  // --------------------------------------------------------------------------
  logic [REM_W-1:0]  rem_sh, trial;
  logic              root_bit;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  assign rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign root_bit = (rem_sh >= trial);
  assign rem_nxt  = root_bit ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_r[ROOT_W-2:0], root_bit};

  // --------------------------------------------------------------------------
  // One CORDIC vectoring step: y is driven to zero, z collects the angle.
  // --------------------------------------------------------------------------
  logic signed [CORD_W-1:0] xs, ys;
  logic signed [ZANG_W-1:0] atan_step;
  logic                     y_pos;
  logic signed [ZANG_W-1:0] tilt_val;

  assign xs        = cx_r >>> cnt_r;
  assign ys        = cy_r >>> cnt_r;
  assign atan_step = $signed({2'b00, atan_deg(cnt_r)});
  assign y_pos     = !cy_r[CORD_W-1] && (cy_r != '0);

  // A zero numerator gives an exact zero tilt; the y tilt is negated.
  always_comb begin
    if (num == '0) begin
      tilt_val = '0;
    end else if (axis_r) begin
      tilt_val = -cz_r;
    end else begin
      tilt_val = cz_r;
    end
  end

  // --------------------------------------------------------------------------
  // Blend: g*(angle+delta) + (1-g)*tilt in 2^-32 degree, rounded half up and
  // saturated to +-256 degrees.
  // --------------------------------------------------------------------------
  logic signed [51:0]        bsum;
  logic signed [35:0]        bres;
  logic signed [ANGLE_W-1:0] ang_new;

  assign bsum = 52'(acc_r) + 52'($signed(prod_r[ACC_W-1:0])) + 52'sd32768;
  assign bres = bsum[51:16];

  always_comb begin
    if (bres > ANG_MAX) begin
      ang_new = ANGLE_W'(ANG_MAX);
    end else if (bres < ANG_MIN) begin
      ang_new = ANGLE_W'(ANG_MIN);
    end else begin
      ang_new = ANGLE_W'(bres);
    end
  end

  // The final blend waits while an older result is still held in the output
  // register, so no result is overwritten.
  logic sat_hold;
  assign sat_hold = axis_r && out_valid_r && out_stall;

  assign in_stall = (state_r != S_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer and control state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      angle_x_r   <= '0;
      angle_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result may be loaded in the same cycle the old one transfers.
      if (state_r == S_SAT && axis_r && !sat_hold) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            axis_r  <= 1'b0;
            state_r <= S_SQA;
          end
        end
        S_SQA: begin
          state_r <= S_SQB;
        end
        S_SQB: begin
          state_r <= S_SQSUM;
        end
        S_SQSUM: begin
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt_r == SQRT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_CORD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_CORD: begin
          if (cnt_r == CORD_LAST) begin
            cnt_r   <= '0;
            state_r <= S_BLG;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_BLG: begin
          state_r <= S_BLT;
        end
        S_BLT: begin
          state_r <= S_SAT;
        end
        S_SAT: begin
          if (!sat_hold) begin
            if (axis_r) begin
              angle_y_r <= ang_new;
              state_r   <= S_IDLE;
            end else begin
              angle_x_r <= ang_new;
              axis_r    <= 1'b1;
              state_r   <= S_SQA;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers (no reset needed).
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      gx_r <= in_gyro_x;
      gy_r <= in_gyro_y;
    end

    if (state_r == S_SQA || state_r == S_SQB || state_r == S_SQSUM ||
        state_r == S_BLG || state_r == S_BLT) begin
      prod_r <= mul_p;
    end

    // The first square is parked while the second one is formed.
    if (state_r == S_SQB) begin
      sq_r <= prod_r[31:0];
    end

    if (state_r == S_SQSUM) begin
      rad_r  <= {sq_r + prod_r[31:0], 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end

    if (state_r == S_SQRT) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      if (cnt_r == SQRT_LAST) begin
        cx_r <= $signed({{(CORD_W-ROOT_W){1'b0}}, root_nxt});
        cy_r <= $signed({{(CORD_W-SAMPLE_W-8){num[SAMPLE_W-1]}}, num, 8'd0});
        cz_r <= '0;
      end
    end

    if (state_r == S_CORD) begin
      if (y_pos) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_step;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_step;
      end
    end

    if (state_r == S_BLG) begin
      tilt_r <= tilt_val;
    end

    if (state_r == S_BLT) begin
      acc_r <= prod_r[ACC_W-1:0];
    end

    if (state_r == S_SAT && axis_r && !sat_hold) begin
      out_x_r <= angle_x_r[TILT_W+7:8];
      out_y_r <= ang_new[TILT_W+7:8];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_tilt_x = out_x_r;
  assign out_tilt_y = out_y_r;

endmodule

FILE: tb/sv/tb_imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// tb_imu_complementary_tilt_filter
// Self-checking bench for the complementary tilt filter: a bit-exact predictor
// of the CORDIC tilt, gyro integration and blend, random traffic on both
// channels, and gain register writes between phases.
// ----------------------------------------------------------------------------
module tb_imu_complementary_tilt_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import imuctf_pkg::*;

  localparam int STEPS        = CORDIC_STEPS_DEF;
  localparam int LATENCY      = 2 * (30 + STEPS);
  localparam int PHASES       = 6;
  localparam int PER_PHASE    = 125;
  localparam longint SAT_HI   = 64'sd16777215;
  localparam longint SAT_LO   = -64'sd16777216;

  // Arctangent of 2^-i in degrees, scaled by 2^16 and rounded to nearest.
  localparam longint ATAN_Q16 [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
    logic signed [SAMPLE_W-1:0] gx;
    logic signed [SAMPLE_W-1:0] gy;
  } imu_sample_t;

  typedef struct packed {
    logic signed [TILT_W-1:0] tilt_x;
    logic signed [TILT_W-1:0] tilt_y;
  } tilt_pair_t;

  // All block inputs start at known values.
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_accel_x = '0;
  logic signed [SAMPLE_W-1:0] in_accel_y = '0;
  logic signed [SAMPLE_W-1:0] in_accel_z = '0;
  logic signed [SAMPLE_W-1:0] in_gyro_x = '0;
  logic signed [SAMPLE_W-1:0] in_gyro_y = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [TILT_W-1:0]   out_tilt_x;
  logic signed [TILT_W-1:0]   out_tilt_y;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // Predictor state: the two stored angles (2^-16 degree) and the gains.
  longint angle_x_q16 = 0;
  longint angle_y_q16 = 0;
  longint blend_gain_cfg = BLEND_GAIN_RST;
  longint step_gain_cfg = STEP_GAIN_RST;

  imu_sample_t pending_samples[$];
  tilt_pair_t  expected_tilts[$];
  imu_sample_t next_sample;
  tilt_pair_t  seen_tilt;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;

  imu_complementary_tilt_filter #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_accel_x(in_accel_x),
    .in_accel_y(in_accel_y),
    .in_accel_z(in_accel_z),
    .in_gyro_x (in_gyro_x),
    .in_gyro_y (in_gyro_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tilt_x(out_tilt_x),
    .out_tilt_y(out_tilt_y),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Bitwise integer square root, floor.
  function automatic longint root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // atan2(num, sqrt(a^2 + b^2)) in 2^-16 degree by CORDIC vectoring. The
  // magnitude carries 8 fraction bits, so the numerator is scaled to match.
  // Shifts of signed longint floor toward minus infinity.
  function automatic longint accel_tilt(longint num, longint a, longint b);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    if (num == 0) return 0;
    x = root_floor(longint'((a * a + b * b) << 16));
    y = num * 256;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z += ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z -= ATAN_Q16[i];
      end
    end
    return z;
  endfunction

  // Gyro integration and blend. The unfiltered sum is not clamped; only the
  // blended angle saturates.
  function automatic longint blend_angle(longint angle, longint rate, longint tilt);
    longint delta;
    longint acc;
    longint r;
    delta = (rate * step_gain_cfg + 32768) >>> 16;
    acc = blend_gain_cfg * (angle + delta) + (65536 - blend_gain_cfg) * tilt;
    r = (acc + 32768) >>> 16;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r;
  endfunction

  function automatic tilt_pair_t predict_tilt(imu_sample_t s);
    tilt_pair_t t;
    longint tx;
    longint ty;
    tx = accel_tilt(s.ay, s.ax, s.az);
    ty = -accel_tilt(s.ax, s.ay, s.az);
    angle_x_q16 = blend_angle(angle_x_q16, s.gx, tx);
    angle_y_q16 = blend_angle(angle_y_q16, s.gy, ty);
    t.tilt_x = TILT_W'(angle_x_q16 >>> 8);
    t.tilt_y = TILT_W'(angle_y_q16 >>> 8);
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_sample(int ax, int ay, int az, int gx, int gy);
    imu_sample_t s;
    s.ax = SAMPLE_W'(ax);
    s.ay = SAMPLE_W'(ay);
    s.az = SAMPLE_W'(az);
    s.gx = SAMPLE_W'(gx);
    s.gy = SAMPLE_W'(gy);
    pending_samples.push_back(s);
  endfunction

  // Random word weighted toward zero, the two extremes and small values, so
  // that the zero-axis and near-vertical cases keep showing up.
  function automatic int rand_word();
    case ($urandom_range(15))
      0:       return 0;
      1:       return 32767;
      2:       return -32768;
      3, 4, 5: return int'($urandom_range(2000)) - 1000;
      default: return int'($signed(SAMPLE_W'($urandom)));
    endcase
  endfunction

  function automatic void queue_random(int n);
    for (int i = 0; i < n; i++) begin
      queue_sample(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Returns once every queued sample has been transferred and every expected
  // result has come back. Checked on the falling edge to stay clear of the
  // clocked processes.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_tilts.size() != 0);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BLEND_GAIN) begin
      blend_gain_cfg = longint'(value[15:0]);
    end else begin
      step_gain_cfg = longint'(value);
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver. A transfer happens at an edge where in_valid is high and
  // in_stall is low; the expectation is computed from the payload on the
  // ports at that edge. A stalled payload is held untouched, and in_valid
  // gets at most one assignment per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_tilts.push_back(predict_tilt({in_accel_x, in_accel_y, in_accel_z,
                                               in_gyro_x, in_gyro_y}));
        samples_sent++;
      end
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = pending_samples.pop_front();
        in_accel_x <= next_sample.ax;
        in_accel_y <= next_sample.ay;
        in_accel_z <= next_sample.az;
        in_gyro_x  <= next_sample.gx;
        in_gyro_y  <= next_sample.gy;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each result transfer is checked against the oldest
  // expectation, one field at a time; out_stall is redrawn every cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tilts.size() == 0) begin
          $display("%0t: result transfer with nothing expected (x %0d, y %0d)",
                   $realtime, out_tilt_x, out_tilt_y);
          mismatch_count++;
        end else begin
          seen_tilt = expected_tilts.pop_front();
          if (out_tilt_x !== seen_tilt.tilt_x) begin
            report_mismatch("tilt_x", out_tilt_x, seen_tilt.tilt_x);
          end
          if (out_tilt_y !== seen_tilt.tilt_y) begin
            report_mismatch("tilt_y", out_tilt_y, seen_tilt.tilt_y);
          end
          results_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence. Phase 0 runs on the reset gains with directed samples
  // first; every later phase drains, rewrites both gains and changes how the
  // two sides idle. Each phase pauses the sender halfway until everything
  // expected has come back.
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          1: begin
            // Pure accelerometer tilt, no gyro contribution at all.
            cfg_write(REG_BLEND_GAIN, 32'd0);
            cfg_write(REG_STEP_GAIN, 32'd0);
          end
          2: begin
            // Nearly full gyro weight with the largest step: the angles saturate.
            cfg_write(REG_BLEND_GAIN, 32'd65535);
            cfg_write(REG_STEP_GAIN, 32'hFFFF_FFFF);
          end
          3: begin
            cfg_write(REG_BLEND_GAIN, 32'd32768);
            cfg_write(REG_STEP_GAIN, $urandom);
          end
          4: begin
            cfg_write(REG_BLEND_GAIN, $urandom_range(65535));
            cfg_write(REG_STEP_GAIN, $urandom_range(4000000));
          end
          default: begin
            cfg_write(REG_BLEND_GAIN, 32'(BLEND_GAIN_RST));
            cfg_write(REG_STEP_GAIN, 32'(STEP_GAIN_RST));
          end
        endcase
      end

      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 72; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase

      @(negedge clk);
      if (p == 0) begin
        // All axes zero, with the gyro rates at their extremes.
        queue_sample(0, 0, 0, 0, 0);
        queue_sample(0, 0, 0, 32767, -32768);
        queue_sample(0, 0, 0, -32768, 32767);
        // Zero denominator: the tilt heads for plus or minus 90 degrees.
        queue_sample(0, 32767, 0, 0, 0);
        queue_sample(0, -32768, 0, 0, 0);
        queue_sample(32767, 0, 0, 0, 0);
        queue_sample(-32768, 0, 0, 0, 0);
        // Level sensor: both numerators zero.
        queue_sample(0, 0, 16384, 0, 0);
        queue_sample(0, 0, -32768, 0, 0);
        queue_sample(32767, 32767, 32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768, -32768, -32768);
        queue_sample(16384, -16384, 0, 100, -100);
        queue_sample(1, -1, 0, 1, -1);
        queue_sample(-1, 1, 1, -1, 1);
        queue_sample(8000, -3000, 15000, -250, 400);
        queue_sample(32767, -32768, 0, 0, 0);
        queue_sample(-32768, -32768, 0, 0, 0);
        queue_sample(32767, -32768, -32768, 1, -1);
      end else if (p == 2) begin
        // Drive the x angle into the upper and then the lower limit, y the other way.
        repeat (4) queue_sample(0, 0, 16384, 32767, -32768);
        repeat (4) queue_sample(0, 0, 16384, -32768, 32767);
      end
      queue_random(PER_PHASE / 2);
      wait_drained();
      queue_random(PER_PHASE - PER_PHASE / 2);
    end

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);

    $display("Sent %0d samples through %0d gain settings with mixed idling.",
             samples_sent, PHASES);
    $display("Checked %0d filtered results, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_imu_complementary_tilt_filter passed");
    end else begin
      $display("tb_imu_complementary_tilt_filter failed");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb_imu_complementary_tilt_filter failed");
    $finish;
  end

endmodule
